/* rtl/isb_pkg.sv */
// ----------------------------------------------------------------------------
// isb_pkg: shared types and constants of the indexed sequence buffer
// Beat layouts, operation codes, sequencer states and store sizing.
// ----------------------------------------------------------------------------
package isb_pkg;

   // store sizing
   localparam int CAPACITY    = 256;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int LEN_W       = 9;

   // operation codes
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_ERASE  = 2'd1;
   localparam logic [1:0] FUNC_GET    = 2'd2;
   localparam logic [1:0] FUNC_SET    = 2'd3;

   // request beat
   typedef struct packed {
      logic [1:0]         func;
      logic [8:0]         index;
      logic signed [31:0] value;
      logic [8:0]         count;
      logic               run_last;
   } req_type;

   // response beat
   typedef struct packed {
      logic signed [31:0] read_value;
      logic               read_valid;
      logic [8:0]         length;
      logic               overflow;
   } rsp_type;

   // store access from the sequencer
   typedef struct packed {
      logic                   wr_en;
      logic [ADDR_W-1:0]      wr_addr;
      logic [VALUE_WIDTH-1:0] wr_data;
      logic                   rd_en;
      logic [ADDR_W-1:0]      rd_addr;
   } mem_ctl_type;

   // sequencer status toward the handshake logic
   typedef struct packed {
      logic ready;
      logic done;
   } seq_stat_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_UP,
      S_UP_END,
      S_PUT,
      S_DOWN,
      S_DOWN_END,
      S_GET,
      S_DONE
   } state_type;

endpackage

/* rtl/isb_ram.sv */
// ----------------------------------------------------------------------------
// isb_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module isb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/isb_seq.sv */
// ----------------------------------------------------------------------------
// isb_seq: operation sequencer of the indexed sequence buffer
// Holds length, insert cursor and run flag, and walks the store one element
// per cycle with a single moving address to open or close gaps.
// ----------------------------------------------------------------------------
module isb_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_take,
   input  isb_pkg::req_type                    req_data,
   input  logic                                out_free,
   input  logic [isb_pkg::VALUE_WIDTH-1:0]     mem_rdata,
   output isb_pkg::mem_ctl_type                mem_ctl,
   output isb_pkg::seq_stat_type               stat,
   output isb_pkg::rsp_type                    rsp
);

   localparam int AW = isb_pkg::ADDR_W;
   localparam int LW = isb_pkg::LEN_W;
   localparam logic [LW-1:0] CAP_LEN = LW'(isb_pkg::CAPACITY);

   isb_pkg::state_type state_ff, state_in;

   isb_pkg::req_type item_ff, item_in;
   logic [LW-1:0] count_ff, count_in;
   logic [LW-1:0] cursor_ff, cursor_in;
   logic          run_ff, run_in;
   logic [LW-1:0] src_ff, src_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic          pend_ff, pend_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] num_ff, num_in;
   logic [isb_pkg::VALUE_WIDTH-1:0] rd_val_ff, rd_val_in;
   logic          rd_ok_ff, rd_ok_in;
   logic          ovf_ff, ovf_in;

   // item decode
   logic [LW-1:0] sel_pos;
   logic [LW-1:0] ins_pos;
   logic          full;
   logic          in_range;
   logic [LW-1:0] avail;
   logic [LW-1:0] erase_n;
   logic [LW-1:0] erase_src;

   // shared address step: one add/subtract on the moving address
   logic          step_down;
   logic [LW-1:0] src_step;
   logic          src_at_end;

   always_comb begin
      sel_pos   = run_ff ? cursor_ff : item_ff.index;
      ins_pos   = (sel_pos > count_ff) ? count_ff : sel_pos;
      full      = (count_ff >= CAP_LEN);
      in_range  = (item_ff.index < count_ff);
      avail     = count_ff - item_ff.index;
      erase_n   = (item_ff.count < avail) ? item_ff.count : avail;
      erase_src = item_ff.index + erase_n;
   end

   assign step_down  = (state_ff == isb_pkg::S_UP);
   assign src_step   = step_down ? (src_ff - LW'(1)) : (src_ff + LW'(1));
   assign src_at_end = step_down ? (src_ff == pos_ff) : (src_ff == (count_ff - LW'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         isb_pkg::S_IDLE: begin
            if (req_take) state_in = isb_pkg::S_PREP;
         end
         isb_pkg::S_PREP: begin
            case (item_ff.func)
               isb_pkg::FUNC_INSERT: begin
                  if (full)                   state_in = isb_pkg::S_DONE;
                  else if (count_ff > ins_pos) state_in = isb_pkg::S_UP;
                  else                        state_in = isb_pkg::S_PUT;
               end
               isb_pkg::FUNC_ERASE: begin
                  if (in_range && (erase_src < count_ff)) state_in = isb_pkg::S_DOWN;
                  else                                    state_in = isb_pkg::S_DONE;
               end
               isb_pkg::FUNC_GET: begin
                  state_in = in_range ? isb_pkg::S_GET : isb_pkg::S_DONE;
               end
               default: state_in = isb_pkg::S_DONE;
            endcase
         end
         isb_pkg::S_UP: begin
            if (src_at_end) state_in = isb_pkg::S_UP_END;
         end
         isb_pkg::S_UP_END:   state_in = isb_pkg::S_PUT;
         isb_pkg::S_PUT:      state_in = isb_pkg::S_DONE;
         isb_pkg::S_DOWN: begin
            if (src_at_end) state_in = isb_pkg::S_DOWN_END;
         end
         isb_pkg::S_DOWN_END: state_in = isb_pkg::S_DONE;
         isb_pkg::S_GET:      state_in = isb_pkg::S_DONE;
         isb_pkg::S_DONE: begin
            if (out_free) state_in = isb_pkg::S_IDLE;
         end
         default: state_in = isb_pkg::S_IDLE;
      endcase
   end

   // store access and status outputs
   always_comb begin
      mem_ctl   = '0;
      stat      = '0;
      case (state_ff)
         isb_pkg::S_IDLE: begin
            stat.ready = 1'b1;
         end
         isb_pkg::S_PREP: begin
            mem_ctl.rd_addr = item_ff.index[AW-1:0];
            mem_ctl.wr_addr = item_ff.index[AW-1:0];
            mem_ctl.wr_data = item_ff.value[isb_pkg::VALUE_WIDTH-1:0];
            if ((item_ff.func == isb_pkg::FUNC_GET) && in_range) mem_ctl.rd_en = 1'b1;
            if ((item_ff.func == isb_pkg::FUNC_SET) && in_range) mem_ctl.wr_en = 1'b1;
         end
         isb_pkg::S_UP, isb_pkg::S_DOWN: begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = src_ff[AW-1:0];
            mem_ctl.wr_en   = pend_ff;
            mem_ctl.wr_addr = dst_ff;
            mem_ctl.wr_data = mem_rdata;
         end
         isb_pkg::S_UP_END, isb_pkg::S_DOWN_END: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = dst_ff;
            mem_ctl.wr_data = mem_rdata;
         end
         isb_pkg::S_PUT: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = pos_ff[AW-1:0];
            mem_ctl.wr_data = item_ff.value[isb_pkg::VALUE_WIDTH-1:0];
         end
         isb_pkg::S_DONE: begin
            stat.done = out_free;
         end
         default: ;
      endcase
   end

   // datapath register updates
   always_comb begin
      item_in   = item_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      run_in    = run_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      pend_in   = pend_ff;
      pos_in    = pos_ff;
      num_in    = num_ff;
      rd_val_in = rd_val_ff;
      rd_ok_in  = rd_ok_ff;
      ovf_in    = ovf_ff;
      case (state_ff)
         isb_pkg::S_IDLE: begin
            if (req_take) begin
               item_in   = req_data;
               rd_val_in = '0;
               rd_ok_in  = 1'b0;
               ovf_in    = 1'b0;
            end
         end
         isb_pkg::S_PREP: begin
            pend_in = 1'b0;
            if (item_ff.func == isb_pkg::FUNC_INSERT) begin
               run_in = ~item_ff.run_last;
               pos_in = ins_pos;
               src_in = count_ff - LW'(1);
               if (full) begin
                  ovf_in    = 1'b1;
                  cursor_in = ins_pos;
               end
            end else begin
               run_in = 1'b0;
               if ((item_ff.func == isb_pkg::FUNC_ERASE) && in_range) begin
                  num_in = erase_n;
                  src_in = erase_src;
                  if (erase_src >= count_ff) count_in = count_ff - erase_n;
               end
            end
         end
         isb_pkg::S_UP: begin
            src_in  = src_step;
            dst_in  = AW'(src_ff + LW'(1));
            pend_in = 1'b1;
         end
         isb_pkg::S_UP_END: begin
            pend_in = 1'b0;
         end
         isb_pkg::S_PUT: begin
            count_in  = count_ff + LW'(1);
            cursor_in = pos_ff + LW'(1);
         end
         isb_pkg::S_DOWN: begin
            src_in  = src_step;
            dst_in  = AW'(src_ff - num_ff);
            pend_in = 1'b1;
         end
         isb_pkg::S_DOWN_END: begin
            pend_in  = 1'b0;
            count_in = count_ff - num_ff;
         end
         isb_pkg::S_GET: begin
            rd_val_in = mem_rdata;
            rd_ok_in  = 1'b1;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= isb_pkg::S_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
         run_ff    <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         run_ff    <= run_in;
         pend_ff   <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      pos_ff    <= pos_in;
      num_ff    <= num_in;
      rd_val_ff <= rd_val_in;
      rd_ok_ff  <= rd_ok_in;
      ovf_ff    <= ovf_in;
   end

   // response fields, stable while in the done state
   always_comb begin
      rsp.read_value = 32'(signed'(rd_val_ff));
      rsp.read_valid = rd_ok_ff;
      rsp.length     = count_ff;
      rsp.overflow   = ovf_ff;
   end

endmodule

/* rtl/indexed_sequence_buffer_unit.sv */
// ----------------------------------------------------------------------------
// indexed_sequence_buffer_unit: ordered store of signed values
// Insert, erase range, get and set on a packed sequence of up to 256 values,
// with a registered response beat.
// ----------------------------------------------------------------------------
//  channel | ports                          | beat
//  --------+--------------------------------+-------------------------------
//  request | req_valid, req_stall, req_data | func, index, value, count, run
//  result  | rsp_valid, rsp_stall, rsp_data | read value/valid, length, ovf
//
//  beat to result: all operations pass prep and done, set writing in prep;
//  get reads there and adds a get state, append adds a put state, an insert
//  that opens a gap first moves the tail up and an erase that closes one moves
//  the later elements down, one element a cycle. the next beat is taken in idle.
//  synchronous reset clears length, cursor and run state; no clearing pass.
//  the sequencer holds in its done state while the output register holds a stalled result.
// ----------------------------------------------------------------------------
module indexed_sequence_buffer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  isb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output isb_pkg::rsp_type rsp_data
);

   isb_pkg::mem_ctl_type            mem_ctl;
   isb_pkg::seq_stat_type           stat;
   isb_pkg::rsp_type                seq_rsp;
   logic [isb_pkg::VALUE_WIDTH-1:0] mem_rdata;
   logic                            req_take;
   logic                            out_free;

   logic             rsp_valid_ff, rsp_valid_in;
   isb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // request handshake
   assign req_stall = ~stat.ready;
   assign req_take  = req_valid & stat.ready;

   // output register handshake
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer
   isb_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_take  (req_take),
      .req_data  (req_data),
      .out_free  (out_free),
      .mem_rdata (mem_rdata),
      .mem_ctl   (mem_ctl),
      .stat      (stat),
      .rsp       (seq_rsp)
   );

   // element store
   isb_ram #(
      .WIDTH (isb_pkg::VALUE_WIDTH),
      .DEPTH (isb_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en),
      .wr_addr (mem_ctl.wr_addr),
      .wr_data (mem_ctl.wr_data),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (mem_ctl.rd_addr),
      .rd_data (mem_rdata)
   );

endmodule
